>>> src/byte_stack_with_rotate_core_assert.svh
// assertion macros for the byte stack
`ifndef BYTE_STACK_WITH_ROTATE_CORE_ASSERT_SVH
`define BYTE_STACK_WITH_ROTATE_CORE_ASSERT_SVH

// property a must hold every cycle outside reset
`define BSR_ASSERT_ALWAYS(label, a) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a)) \
        else $error("assertion failed");

// implication a |=> b
`define BSR_ASSERT_NEXT(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`endif

>>> src/bsr_pkg.sv
`default_nettype none
package bsr_pkg;

    localparam int DEFAULT_MAX_DEPTH = 32;

    typedef enum logic [2:0] {
        REQ_PUSH   = 3'd0,
        REQ_POP    = 3'd1,
        REQ_PEEK   = 3'd2,
        REQ_DUP    = 3'd3,
        REQ_ROT_UP = 3'd4,
        REQ_ROT_DN = 3'd5,
        REQ_PRINT  = 3'd6,
        REQ_NONE   = 3'd7
    } req_t;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;
    localparam logic [1:0] ST_INVALID = 2'd3;

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] push_byte;
        logic [5:0] rotate_count;
    } in_word_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] data_byte;
        logic       data_valid;
        logic       last_of_run;
    } out_word_t;

endpackage
`default_nettype wire

>>> src/byte_stack_with_rotate_core.sv
// each word passes through the idle, read and execute states; execute waits while a result is unread
// the back end takes a new word only when idle; the front queue holds up to two waiting words
// rotate by n >= 2: one entry moved per read/write pair
// print of k entries: one byte per entry, from the top down
// reset: asynchronous, stack empty, capacity 32; memory contents undefined
`default_nettype none
module byte_stack_with_rotate_core
    import bsr_pkg::*;
#(
    parameter int MAX_DEPTH = DEFAULT_MAX_DEPTH
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic [5:0] cfg_data,
    input  wire logic      cfg_valid,
    output logic           cfg_ready,
    input  wire in_word_t  in_data,
    input  wire logic      in_valid,
    output logic           in_ready,
    output out_word_t      out_data,
    output logic           out_valid,
    input  wire logic      out_ready
);
`include "byte_stack_with_rotate_core_assert.svh"

    logic [5:0] cap_reg;
    in_word_t   q_data;
    logic       q_valid, q_ready, busy;

    assign cfg_ready = 1'b1;

    // capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_reg <= 6'd32;
        else if (cfg_valid)
            cap_reg <= cfg_data;
    end

    bsr_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_data(in_data), .in_valid(in_valid), .in_ready(in_ready),
        .q_data(q_data), .q_valid(q_valid), .q_ready(q_ready)
    );

    bsr_back #(.MAX_DEPTH(MAX_DEPTH)) u_back (
        .clk(clk), .rst_n(rst_n), .capacity(cap_reg),
        .q_data(q_data), .q_valid(q_valid), .q_ready(q_ready),
        .out_data(out_data), .out_valid(out_valid), .out_ready(out_ready),
        .busy(busy)
    );

    // checks
    `BSR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
    `BSR_ASSERT_ALWAYS(a_busy_out, !out_valid || busy)
    `BSR_ASSERT_ALWAYS(a_data_zero, out_data.data_valid || out_data.data_byte == 8'd0 || !out_valid)
endmodule
`default_nettype wire

>>> src/bsr_front.sv
`default_nettype none
// front end: takes request words into a two-entry queue, drops type 7
module bsr_front
    import bsr_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire in_word_t in_data,
    input  wire logic     in_valid,
    output logic          in_ready,
    output in_word_t      q_data,
    output logic          q_valid,
    input  wire logic     q_ready
);
    in_word_t   buf_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       rd_reg, rd_next;
    logic       wr_reg, wr_next;
    logic       push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready && (req_t'(in_data.req_type) != REQ_NONE);
    assign pop      = q_valid && q_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_data   = buf_reg[rd_reg];

    // queue pointers
    always_comb
    begin
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
        rd_next  = rd_reg ^ pop;
        wr_next  = wr_reg ^ push;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
            buf_reg[wr_reg] <= in_data;
    end
endmodule
`default_nettype wire

>>> src/bsr_back.sv
`default_nettype none
// back end: executes one request at a time on the stack memory
module bsr_back
    import bsr_pkg::*;
#(
    parameter int MAX_DEPTH = DEFAULT_MAX_DEPTH
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic [5:0] capacity,
    input  wire in_word_t q_data,
    input  wire logic     q_valid,
    output logic          q_ready,
    output out_word_t     out_data,
    output logic          out_valid,
    input  wire logic     out_ready,
    output logic          busy
);
    localparam int AW = $clog2(MAX_DEPTH);
    localparam int CW = $clog2(MAX_DEPTH + 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_READ  = 6'b000010,
        S_EXEC  = 6'b000100,
        S_ROT   = 6'b001000,
        S_PRINT = 6'b010000,
        S_LAST  = 6'b100000
    } state_t;

    logic [7:0] mem [MAX_DEPTH];
    logic [7:0] rdata_reg;
    logic [AW-1:0] raddr;
    logic          rd_en;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;
    logic          we;

    state_t state_reg, state_next;
    in_word_t req_reg, req_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] stop_reg, stop_next;
    logic [7:0] hold_reg, hold_next;
    out_word_t obuf_reg, obuf_next;
    logic ovalid_reg, ovalid_next;
    logic [CW:0] lim;
    logic room;
    logic ospace;
    req_t rq;

    assign rq       = req_t'(req_reg.req_type);
    assign ospace   = !ovalid_reg || out_ready;
    assign out_data = obuf_reg;
    assign out_valid = ovalid_reg;
    assign q_ready  = (state_reg == S_IDLE);
    assign busy     = (state_reg != S_IDLE) || ovalid_reg;

    // capacity limit saturates at the depth
    always_comb
    begin
        if ({1'b0, capacity} > 7'(MAX_DEPTH))
            lim = (CW+1)'(MAX_DEPTH);
        else
            lim = (CW+1)'(capacity);
    end
    assign room = ({1'b0, count_reg} < lim);

    // memory with registered read
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (rd_en)
            rdata_reg <= mem[raddr];
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        req_next    = req_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        stop_next   = stop_reg;
        hold_next   = hold_reg;
        obuf_next   = obuf_reg;
        ovalid_next = ovalid_reg && !out_ready;
        raddr = '0;
        rd_en = 1'b0;
        waddr = '0;
        wdata = rdata_reg;
        we    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    req_next   = q_data;
                    raddr      = AW'(count_reg - 1'b1);
                    rd_en      = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (ospace)
                begin
                    ovalid_next = 1'b1;
                    obuf_next   = '{ST_OK, 8'd0, 1'b0, 1'b1};
                    state_next  = S_IDLE;
                    unique case (rq)
                        REQ_PUSH:
                        begin
                            if (!room)
                                obuf_next.status = ST_FULL;
                            else
                            begin
                                we = 1'b1;
                                waddr = AW'(count_reg);
                                wdata = req_reg.push_byte;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        REQ_POP, REQ_PEEK:
                        begin
                            if (count_reg == '0)
                                obuf_next.status = ST_EMPTY;
                            else
                            begin
                                obuf_next.data_byte  = rdata_reg;
                                obuf_next.data_valid = 1'b1;
                                if (rq == REQ_POP)
                                    count_next = count_reg - 1'b1;
                            end
                        end
                        REQ_DUP:
                        begin
                            if (count_reg == '0)
                                obuf_next.status = ST_EMPTY;
                            else if (!room)
                                obuf_next.status = ST_FULL;
                            else
                            begin
                                we = 1'b1;
                                waddr = AW'(count_reg);
                                count_next = count_reg + 1'b1;
                            end
                        end
                        REQ_ROT_UP, REQ_ROT_DN:
                        begin
                            if ({1'b0, req_reg.rotate_count} > 7'(count_reg))
                                obuf_next.status = ST_INVALID;
                            else if (req_reg.rotate_count >= 6'd2)
                            begin
                                ovalid_next = ovalid_reg && !out_ready;
                                state_next  = S_ROT;
                                stop_next   = CW'(7'(count_reg) - {1'b0, req_reg.rotate_count});
                                if (rq == REQ_ROT_UP)
                                begin
                                    hold_next = rdata_reg;
                                    idx_next  = count_reg - 1'b1;
                                    raddr = AW'(count_reg - 2'd2);
                                end
                                else
                                begin
                                    idx_next = stop_next;
                                    raddr = AW'(stop_next);
                                end
                                rd_en = 1'b1;
                            end
                        end
                        REQ_PRINT:
                        begin
                            if (count_reg != '0)
                            begin
                                ovalid_next = ovalid_reg && !out_ready;
                                idx_next    = count_reg - 1'b1;
                                state_next  = S_PRINT;
                            end
                        end
                        default:
                        begin
                            ovalid_next = ovalid_reg && !out_ready;
                        end
                    endcase
                end
            end
            S_ROT:
            begin
                // one entry moved per S_ROT/S_LAST pair: S_ROT waits for the read, S_LAST writes and reads next
                state_next = S_LAST;
            end
            S_LAST:
            begin
                if (rq == REQ_ROT_UP)
                begin
                    if (idx_reg == stop_reg)
                    begin
                        we = 1'b1; waddr = AW'(idx_reg); wdata = hold_reg;
                        state_next = S_EXEC;
                        req_next.req_type = REQ_ROT_UP;
                        req_next.rotate_count = 6'd0;
                    end
                    else
                    begin
                        we = 1'b1; waddr = AW'(idx_reg); wdata = rdata_reg;
                        idx_next = idx_reg - 1'b1;
                        if (idx_reg - 1'b1 != stop_reg)
                        begin
                            raddr = AW'(idx_reg - 2'd2);
                            rd_en = 1'b1;
                        end
                        state_next = S_ROT;
                    end
                end
                else
                begin
                    if (idx_reg == stop_reg)
                        hold_next = rdata_reg;
                    if (idx_reg == count_reg - 1'b1)
                    begin
                        // old top moves down one, saved byte goes on top next cycle
                        we = 1'b1; waddr = AW'(idx_reg - 1'b1); wdata = rdata_reg;
                        stop_next = idx_reg;
                        state_next = S_LAST;
                        req_next.req_type = REQ_ROT_UP;
                    end
                    else
                    begin
                        raddr = AW'(idx_reg + 1'b1);
                        rd_en = 1'b1;
                        if (idx_reg != stop_reg)
                        begin
                            we = 1'b1; waddr = AW'(idx_reg - 1'b1); wdata = rdata_reg;
                        end
                        idx_next = idx_reg + 1'b1;
                        state_next = S_ROT;
                    end
                end
            end
            S_PRINT:
            begin
                raddr = AW'(idx_reg);
                rd_en = 1'b1;
                state_next = S_READ;
                req_next.req_type = REQ_NONE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        // print emission when queued read returns
        if (state_reg == S_EXEC && rq == REQ_NONE)
        begin
            state_next  = S_EXEC;
            ovalid_next = ovalid_reg && !out_ready;
            if (ospace)
            begin
                ovalid_next = 1'b1;
                obuf_next   = '{ST_OK, rdata_reg, 1'b1, idx_reg == '0};
                if (idx_reg == '0)
                    state_next = S_IDLE;
                else
                begin
                    idx_next   = idx_reg - 1'b1;
                    state_next = S_PRINT;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        idx_reg  <= idx_next;
        stop_reg <= stop_next;
        hold_reg <= hold_next;
        obuf_reg <= obuf_next;
    end
endmodule
`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
    import bsr_pkg::*;

    localparam int DEPTH = 32;

    logic      clk;
    logic      rst_n;
    logic [5:0] cfg_data;
    logic      cfg_valid;
    logic      cfg_ready;
    in_word_t  in_data;
    logic      in_valid;
    logic      in_ready;
    out_word_t out_data;
    logic      out_valid;
    logic      out_ready;

    byte_stack_with_rotate_core #(.MAX_DEPTH(DEPTH)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_data(cfg_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .in_data(in_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .out_data(out_data),
        .out_valid(out_valid),
        .out_ready(out_ready)
    );

    // shadow copy of the stack
    logic [7:0]  shadow_stack [DEPTH];
    int unsigned shadow_count;
    int unsigned shadow_cap;

    in_word_t  pending_words [$];
    out_word_t expected_words [$];
    int        fail_count;
    int        send_idle_pct;
    int        recv_idle_pct;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic out_word_t make_word(logic [1:0] st, logic [7:0] b, logic v, logic l);
        out_word_t w;
        w.status      = st;
        w.data_byte   = b;
        w.data_valid  = v;
        w.last_of_run = l;
        return w;
    endfunction

    // compute the results one request causes and update the shadow stack
    function automatic void predict_request(in_word_t w);
        int unsigned lim;
        int unsigned n;
        int unsigned base;
        logic [7:0]  tmp;
        lim = (shadow_cap > DEPTH) ? DEPTH : shadow_cap;
        n = w.rotate_count;
        case (req_t'(w.req_type))
            REQ_PUSH:
            begin
                if (shadow_count >= lim)
                    expected_words.push_back(make_word(ST_FULL, 8'd0, 1'b0, 1'b1));
                else
                begin
                    shadow_stack[shadow_count] = w.push_byte;
                    shadow_count++;
                    expected_words.push_back(make_word(ST_OK, 8'd0, 1'b0, 1'b1));
                end
            end
            REQ_POP, REQ_PEEK:
            begin
                if (shadow_count == 0)
                    expected_words.push_back(make_word(ST_EMPTY, 8'd0, 1'b0, 1'b1));
                else
                begin
                    tmp = shadow_stack[shadow_count - 1];
                    if (w.req_type == REQ_POP)
                        shadow_count--;
                    expected_words.push_back(make_word(ST_OK, tmp, 1'b1, 1'b1));
                end
            end
            REQ_DUP:
            begin
                if (shadow_count == 0)
                    expected_words.push_back(make_word(ST_EMPTY, 8'd0, 1'b0, 1'b1));
                else if (shadow_count >= lim)
                    expected_words.push_back(make_word(ST_FULL, 8'd0, 1'b0, 1'b1));
                else
                begin
                    shadow_stack[shadow_count] = shadow_stack[shadow_count - 1];
                    shadow_count++;
                    expected_words.push_back(make_word(ST_OK, 8'd0, 1'b0, 1'b1));
                end
            end
            REQ_ROT_UP, REQ_ROT_DN:
            begin
                if (n > shadow_count)
                    expected_words.push_back(make_word(ST_INVALID, 8'd0, 1'b0, 1'b1));
                else
                begin
                    if (n >= 2)
                    begin
                        base = shadow_count - n;
                        if (w.req_type == REQ_ROT_UP)
                        begin
                            tmp = shadow_stack[shadow_count - 1];
                            for (int i = shadow_count - 1; i > base; i--)
                                shadow_stack[i] = shadow_stack[i - 1];
                            shadow_stack[base] = tmp;
                        end
                        else
                        begin
                            tmp = shadow_stack[base];
                            for (int i = base; i + 1 < shadow_count; i++)
                                shadow_stack[i] = shadow_stack[i + 1];
                            shadow_stack[shadow_count - 1] = tmp;
                        end
                    end
                    expected_words.push_back(make_word(ST_OK, 8'd0, 1'b0, 1'b1));
                end
            end
            REQ_PRINT:
            begin
                if (shadow_count == 0)
                    expected_words.push_back(make_word(ST_OK, 8'd0, 1'b0, 1'b1));
                else
                    for (int i = 0; i < shadow_count; i++)
                        expected_words.push_back(make_word(ST_OK,
                            shadow_stack[shadow_count - 1 - i], 1'b1,
                            (i + 1 == shadow_count)));
            end
            default: ;
        endcase
    endfunction

    function automatic in_word_t make_req(req_t r, logic [7:0] b, logic [5:0] n);
        in_word_t w;
        w.req_type     = r;
        w.push_byte    = b;
        w.rotate_count = n;
        return w;
    endfunction

    // random request, weighted toward pushes so the stack gets deep
    function automatic in_word_t rand_req(int unsigned fill);
        int unsigned pick;
        logic [5:0]  n;
        pick = $urandom_range(0, 99);
        if (fill > 0 && $urandom_range(0, 3) != 0)
            n = 6'($urandom_range(0, fill));
        else
            n = 6'($urandom_range(0, 63));
        if (pick < 35)
            return make_req(REQ_PUSH, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)));
        else if (pick < 50)
            return make_req(REQ_POP, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)));
        else if (pick < 58)
            return make_req(REQ_PEEK, 8'($urandom_range(0, 255)), n);
        else if (pick < 68)
            return make_req(REQ_DUP, 8'($urandom_range(0, 255)), n);
        else if (pick < 79)
            return make_req(REQ_ROT_UP, 8'($urandom_range(0, 255)), n);
        else if (pick < 90)
            return make_req(REQ_ROT_DN, 8'($urandom_range(0, 255)), n);
        else if (pick < 96)
            return make_req(REQ_PRINT, 8'($urandom_range(0, 255)), n);
        else
            return make_req(REQ_NONE, 8'($urandom_range(0, 255)), n);
    endfunction

    // driver: feeds queued words, predicting on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                predict_request(in_data);
            if (!in_valid || in_ready)
            begin
                if (pending_words.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    in_data  <= pending_words.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor: checks each result word against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected word %p", $time, out_data);
                fail_count++;
            end
            else
            begin
                out_word_t exp_w;
                exp_w = expected_words.pop_front();
                if (out_data.status !== exp_w.status
                    || out_data.data_byte !== exp_w.data_byte
                    || out_data.data_valid !== exp_w.data_valid
                    || out_data.last_of_run !== exp_w.last_of_run)
                begin
                    $display("%0t: mismatch expected %p actual %p", $time, exp_w, out_data);
                    fail_count++;
                end
            end
        end
        if (rst_n)
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        else
            out_ready <= 1'b0;
    end

    // wait for the block to drain and settle
    task automatic wait_drained();
        while (pending_words.size() > 0 || in_valid || expected_words.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_capacity(logic [5:0] value);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        shadow_cap = value;
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random(int count);
        int unsigned fill;
        fill = shadow_count;
        for (int i = 0; i < count; i++)
        begin
            in_word_t w;
            w = rand_req(fill);
            if (w.req_type == REQ_PUSH || w.req_type == REQ_DUP)
                fill = (fill < DEPTH) ? fill + 1 : fill;
            else if (w.req_type == REQ_POP && fill > 0)
                fill--;
            pending_words.push_back(w);
        end
    endtask

    // stimulus
    initial
    begin
        logic [5:0] caps [6];
        caps = '{6'd32, 6'd1, 6'd63, 6'd0, 6'd5, 6'd17};
        fail_count    = 0;
        shadow_count  = 0;
        shadow_cap    = 32;
        send_idle_pct = 10;
        recv_idle_pct = 70;
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty cases, extremes, every operation
        pending_words.push_back(make_req(REQ_POP, 8'h00, 6'd0));
        pending_words.push_back(make_req(REQ_PEEK, 8'h00, 6'd0));
        pending_words.push_back(make_req(REQ_DUP, 8'h00, 6'd0));
        pending_words.push_back(make_req(REQ_PRINT, 8'h00, 6'd0));
        pending_words.push_back(make_req(REQ_ROT_UP, 8'h00, 6'd1));
        pending_words.push_back(make_req(REQ_ROT_DN, 8'h00, 6'd0));
        pending_words.push_back(make_req(REQ_PUSH, 8'hFF, 6'd63));
        pending_words.push_back(make_req(REQ_PUSH, 8'h00, 6'd0));
        pending_words.push_back(make_req(REQ_PUSH, 8'hA5, 6'd0));
        pending_words.push_back(make_req(REQ_DUP, 8'h5A, 6'd0));
        pending_words.push_back(make_req(REQ_ROT_UP, 8'h00, 6'd3));
        pending_words.push_back(make_req(REQ_ROT_DN, 8'h00, 6'd4));
        pending_words.push_back(make_req(REQ_ROT_UP, 8'h00, 6'd5));
        pending_words.push_back(make_req(REQ_ROT_DN, 8'h00, 6'd63));
        pending_words.push_back(make_req(REQ_ROT_UP, 8'h00, 6'd1));
        pending_words.push_back(make_req(REQ_NONE, 8'hFF, 6'd63));
        pending_words.push_back(make_req(REQ_PEEK, 8'h00, 6'd0));
        pending_words.push_back(make_req(REQ_PRINT, 8'h00, 6'd0));
        pending_words.push_back(make_req(REQ_POP, 8'h00, 6'd0));
        wait_drained();

        // fill to the top for full cases, then random phases at several capacities
        for (int i = 0; i < 34; i++)
            pending_words.push_back(make_req(REQ_PUSH, 8'($urandom_range(0, 255)), 6'd0));
        pending_words.push_back(make_req(REQ_DUP, 8'h00, 6'd0));
        pending_words.push_back(make_req(REQ_ROT_UP, 8'h00, 6'd32));
        pending_words.push_back(make_req(REQ_ROT_DN, 8'h00, 6'd32));
        pending_words.push_back(make_req(REQ_PRINT, 8'h00, 6'd0));
        wait_drained();

        for (int p = 0; p < 6; p++)
        begin
            if (p == 2)
            begin
                send_idle_pct = 70;
                recv_idle_pct = 10;
            end
            else if (p == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_capacity(caps[p]);
            run_random(60);
            wait_drained();
        end

        // drain: everything already waited out
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // watchdog
    initial
    begin
        #20ms;
        $display("FAIL");
        $finish;
    end

endmodule

>>> files.f
+incdir+src
src/bsr_pkg.sv
src/bsr_front.sv
src/bsr_back.sv
src/byte_stack_with_rotate_core.sv
tb/tb_top.sv
